>>> design/interleaving_string_check_defines.svh
// Assertion macros shared by the interleaving check checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef INTERLEAVING_STRING_CHECK_DEFINES_SVH
`define INTERLEAVING_STRING_CHECK_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ISC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interleaving check: same-cycle assertion failed");

// Next-cycle implication, masked during reset.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interleaving check: next-cycle assertion failed");

`endif

>>> design/isc_pkg.sv
// Package for the interleaving string check: sizes, payload structs, codes.
// No dependencies.
package isc_pkg;

    localparam int MAX_LEN    = 64;
    localparam int TARGET_CAP = 2 * MAX_LEN;
    localparam int FIRST_AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TARGET_AW  = $clog2(TARGET_CAP);
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int TLEN_W     = $clog2(TARGET_CAP + 1);
    localparam int ROW_DEPTH  = MAX_LEN + 1;

    typedef enum logic [1:0] {
        ACT_FIRST   = 2'd0,
        ACT_SECOND  = 2'd1,
        ACT_TARGET  = 2'd2,
        ACT_COMPUTE = 2'd3
    } isc_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } isc_state_t;

    typedef struct packed {
        isc_action_t action;
        logic [7:0]  symbol;
    } isc_in_t;

    typedef struct packed {
        logic interleaved;
        logic overflowed;
    } isc_out_t;

endpackage

>>> design/interleaving_string_check.sv
// Interleaving string check. Loads are taken one per cycle, back to back, when idle.
// Compute: on overflow or length mismatch, straight to ST_FINISH, which registers
// the result once the output is free; otherwise each table cell is a read state and
// an evaluate state through the reach-row memory. No input taken while computing.
// Reset (aresetn, synchronous) clears lengths, overflow flag, FSM and output
// valid; the string stores and the reach row are not cleared.
module interleaving_string_check
    import isc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  isc_in_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output isc_out_t m_data
);

    // ------------------------------------------------------------------
    // Control and length state
    // ------------------------------------------------------------------
    isc_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   first_len_reg, first_len_next;
    logic [LEN_W-1:0]   second_len_reg, second_len_next;
    logic [TLEN_W-1:0]  tgt_len_reg, tgt_len_next;
    logic               ovf_reg, ovf_next;
    logic [LEN_W-1:0]   i_reg, i_next;      // table row, 0..n
    logic [LEN_W-1:0]   j_reg, j_next;      // table column, 0..m
    logic               left_reg, left_next; // cell just computed in this row
    logic               result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    isc_out_t           out_data_reg, out_data_next;

    logic               accept;
    logic               is_compute;
    logic               len_mismatch;
    logic               last_cell;
    logic               out_free;

    // store and row memory ports
    logic               first_we, second_we, tgt_we, row_we;
    logic [7:0]         first_rd, second_rd, tgt_rd;
    logic               row_rd;
    logic               cell_bit;
    logic               from_up, from_left;
    logic [LEN_W-1:0]   i_m1, j_m1;
    logic [TLEN_W-1:0]  t_index;

    assign accept     = s_valid && s_ready;
    assign is_compute = (s_data.action == ACT_COMPUTE);
    assign out_free   = !out_valid_reg || m_ready;

    // lengths must add up; the sum never exceeds the target counter's range
    assign len_mismatch = (TLEN_W'(first_len_reg) + TLEN_W'(second_len_reg)) != tgt_len_reg;

    assign last_cell = (i_reg == first_len_reg) && (j_reg == second_len_reg);

    // ------------------------------------------------------------------
    // Read addresses for cell (i, j). The stores are read at i-1, j-1 and
    // i+j-1; reads that fall outside the written range are masked below.
    // ------------------------------------------------------------------
    assign i_m1    = i_reg - LEN_W'(1);
    assign j_m1    = j_reg - LEN_W'(1);
    assign t_index = TLEN_W'(i_reg) + TLEN_W'(j_reg) - TLEN_W'(1);

    isc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
        .aclk    (aclk),
        .wr_en   (first_we),
        .wr_addr (first_len_reg[FIRST_AW-1:0]),
        .wr_data (s_data.symbol),
        .rd_addr (i_m1[FIRST_AW-1:0]),
        .rd_data (first_rd)
    );

    isc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
        .aclk    (aclk),
        .wr_en   (second_we),
        .wr_addr (second_len_reg[FIRST_AW-1:0]),
        .wr_data (s_data.symbol),
        .rd_addr (j_m1[FIRST_AW-1:0]),
        .rd_data (second_rd)
    );

    isc_ram #(.WIDTH(8), .DEPTH(TARGET_CAP)) u_target_ram (
        .aclk    (aclk),
        .wr_en   (tgt_we),
        .wr_addr (tgt_len_reg[TARGET_AW-1:0]),
        .wr_data (s_data.symbol),
        .rd_addr (t_index[TARGET_AW-1:0]),
        .rd_data (tgt_rd)
    );

    // Reach row: read in ST_READ, written in ST_EVAL. The two phases never
    // overlap, so a cell never sees a stale "up" value.
    isc_ram #(.WIDTH(1), .DEPTH(ROW_DEPTH)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (row_we),
        .wr_addr (j_reg),
        .wr_data (cell_bit),
        .rd_addr (j_reg),
        .rd_data (row_rd)
    );

    // ------------------------------------------------------------------
    // Cell evaluation (valid in ST_EVAL, data read during ST_READ).
    // Top row has no "up", left column has no "left", origin is true.
    // ------------------------------------------------------------------
    assign from_up   = (i_reg != '0) && row_rd && (first_rd == tgt_rd);
    assign from_left = (j_reg != '0) && left_reg && (second_rd == tgt_rd);
    assign cell_bit  = ((i_reg == '0) && (j_reg == '0)) || from_up || from_left;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && is_compute) begin
                    if (ovf_reg || len_mismatch) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (last_cell) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        s_ready         = 1'b0;
        first_we        = 1'b0;
        second_we       = 1'b0;
        tgt_we          = 1'b0;
        row_we          = 1'b0;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        tgt_len_next    = tgt_len_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        left_next       = left_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    case (s_data.action)
                        ACT_FIRST: begin
                            if (first_len_reg == LEN_W'(MAX_LEN)) begin
                                ovf_next = 1'b1;
                            end else begin
                                first_we       = 1'b1;
                                first_len_next = first_len_reg + LEN_W'(1);
                            end
                        end
                        ACT_SECOND: begin
                            if (second_len_reg == LEN_W'(MAX_LEN)) begin
                                ovf_next = 1'b1;
                            end else begin
                                second_we       = 1'b1;
                                second_len_next = second_len_reg + LEN_W'(1);
                            end
                        end
                        ACT_TARGET: begin
                            if (tgt_len_reg == TLEN_W'(TARGET_CAP)) begin
                                ovf_next = 1'b1;
                            end else begin
                                tgt_we       = 1'b1;
                                tgt_len_next = tgt_len_reg + TLEN_W'(1);
                            end
                        end
                        ACT_COMPUTE: begin
                            // false unless the table walk says otherwise
                            result_next = 1'b0;
                            i_next      = '0;
                            j_next      = '0;
                        end
                        default: begin
                            result_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // addresses already on the RAM ports; data lands next cycle
            end
            ST_EVAL: begin
                row_we    = 1'b1;
                left_next = cell_bit;
                if (last_cell) begin
                    result_next = cell_bit;
                end else if (j_reg == second_len_reg) begin
                    j_next = '0;
                    i_next = i_reg + LEN_W'(1);
                end else begin
                    j_next = j_reg + LEN_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.interleaved = result_reg && !ovf_reg;
                    out_data_next.overflowed  = ovf_reg;
                    first_len_next            = '0;
                    second_len_next           = '0;
                    tgt_len_next              = '0;
                    ovf_next                  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            tgt_len_reg    <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            tgt_len_reg    <= tgt_len_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        left_reg     <= left_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> design/isc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module isc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/isc_checker.sv
// Port-level checker for the interleaving string check, bound to the top level.
// Depends on isc_pkg and interleaving_string_check_defines.svh.
`include "interleaving_string_check_defines.svh"

module isc_checker
    import isc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input isc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input isc_out_t m_data
);

    // a stalled result holds
    `ISC_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ISC_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_data))

    // overflow always forces a false answer
    `ISC_ASSERT_NOW(a_ovf_false, aclk, aresetn, m_valid && m_data.overflowed,
                    !m_data.interleaved)

    // a load never produces a result
    `ISC_ASSERT_NEXT(a_load_quiet, aclk, aresetn,
                     s_valid && s_ready && (s_data.action != ACT_COMPUTE), !$rose(m_valid))

    // a compute transaction keeps the input side closed the next cycle
    `ISC_ASSERT_NEXT(a_compute_busy, aclk, aresetn,
                     s_valid && s_ready && (s_data.action == ACT_COMPUTE), !s_ready)

endmodule

bind interleaving_string_check isc_checker u_isc_checker (.*);
